/* rtl/fuct_pkg.sv */
// shared types and constants of the file usage count table
// no dependencies; used by file_usage_count_table
package fuct_pkg;

  localparam int REQ_W   = 4;
  localparam int FN_W    = 7;
  localparam int VAL_W   = 32;
  localparam int USAGE_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET          = 4'd0,
    REQ_SET_USAGE    = 4'd1,
    REQ_INC          = 4'd2,
    REQ_DEC          = 4'd3,
    REQ_SET_STAMP    = 4'd4,
    REQ_CHECK_STAMP  = 4'd5,
    REQ_CHECK_FINISH = 4'd6,
    REQ_TRY_FINISH   = 4'd7,
    REQ_PENDING      = 4'd8
  } req_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic               pend;
    logic [VAL_W-1:0]   stamp;
    logic [USAGE_W-1:0] usage;
  } entry_t;

endpackage

/* rtl/fuct_ram.sv */
// generic single-clock ram: one write port, one read port, registered read
// read during a write to the same address returns the old data; no dependencies
module fuct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/file_usage_count_table.sv */
// top level of the file usage count table
// uses fuct_pkg and one fuct_ram instance holding all entries
//
// Each request item addresses one entry by file number (1..ENTRIES) and gives
// exactly one result item, registered through the request stage and then the
// output register: the entry's usage count after the request, a boolean answer
// for check, finish and pending requests, and a miss flag for file numbers
// outside the table. The entries live in a single ram with a registered read;
// every request is one read-modify-write, and the last write is forwarded to
// the next read, so the block sustains one item per cycle while the result
// side keeps up. After reset the ram is cleared one entry per cycle; no item
// is accepted during that pass.
module file_usage_count_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fuct_pkg::REQ_W-1:0]   req_type,
  input  logic [fuct_pkg::FN_W-1:0]    file_number,
  input  logic [fuct_pkg::VAL_W-1:0]   operand_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fuct_pkg::USAGE_W-1:0] usage_out,
  output logic                         answer_flag,
  output logic                         miss
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = $bits(fuct_pkg::entry_t);

  // clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  // request stage, waiting on ram read data
  logic                       s1_v;
  logic [fuct_pkg::REQ_W-1:0] s1_req;
  logic [IDX_W-1:0]           s1_idx;
  logic [fuct_pkg::VAL_W-1:0] s1_val;
  logic                       s1_miss;
  logic                       s1_adv;

  // last write, forwarded to the read that overlapped it
  logic             fwd_v;
  logic [IDX_W-1:0] fwd_idx;
  fuct_pkg::entry_t fwd_data;

  logic                       accept;
  logic [fuct_pkg::FN_W-1:0]  fn_m1;
  logic [IDX_W-1:0]           in_idx;
  logic                       in_miss;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  fuct_pkg::entry_t upd;
  logic             upd_we;
  logic             upd_ans;

  assign fn_m1   = file_number - fuct_pkg::FN_W'(1);
  assign in_idx  = IDX_W'(fn_m1);
  assign in_miss = (file_number == '0) || (32'(file_number) > ENTRIES);

  assign s1_adv   = s1_v && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_v || s1_adv);
  assign accept   = in_valid && in_ready;

  // entry update for the request in stage one
  always_comb begin
    fuct_pkg::entry_t src;
    src     = (fwd_v && (fwd_idx == s1_idx)) ? fwd_data : fuct_pkg::entry_t'(ram_rdata);
    upd     = src;
    upd_we  = 1'b1;
    upd_ans = 1'b0;
    unique case (fuct_pkg::req_t'(s1_req))
      fuct_pkg::REQ_GET: begin
        upd_we = 1'b0;
      end
      fuct_pkg::REQ_SET_USAGE: begin
        upd.usage = (|s1_val[fuct_pkg::VAL_W-1:fuct_pkg::USAGE_W]) ? '1
                  : s1_val[fuct_pkg::USAGE_W-1:0];
      end
      fuct_pkg::REQ_INC: begin
        if (src.usage != '1) begin
          upd.usage = src.usage + fuct_pkg::USAGE_W'(1);
        end
      end
      fuct_pkg::REQ_DEC: begin
        if (src.usage <= fuct_pkg::USAGE_W'(1)) begin
          upd.usage = '0;
          upd.stamp = '0;
        end else begin
          upd.usage = src.usage - fuct_pkg::USAGE_W'(1);
        end
      end
      fuct_pkg::REQ_SET_STAMP: begin
        upd.stamp = s1_val;
      end
      fuct_pkg::REQ_CHECK_STAMP: begin
        upd_we  = 1'b0;
        upd_ans = (src.stamp == s1_val) || (src.stamp == '0);
      end
      fuct_pkg::REQ_CHECK_FINISH: begin
        if (src.pend && (src.usage == '0)) begin
          upd.stamp = '0;
          upd.pend  = 1'b0;
          upd_ans   = 1'b1;
        end
      end
      fuct_pkg::REQ_TRY_FINISH: begin
        if (src.usage == '0) begin
          upd.stamp = '0;
          upd_ans   = 1'b1;
        end else begin
          upd.pend = 1'b1;
        end
      end
      fuct_pkg::REQ_PENDING: begin
        upd_we  = 1'b0;
        upd_ans = src.pend;
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  // the clearing pass and the request stage share the write port
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && !s1_miss && upd_we;
      ram_waddr = s1_idx;
      ram_wdata = ENT_W'(upd);
    end
  end

  fuct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      s1_v      <= 1'b0;
      fwd_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_idx == IDX_W'(ENTRIES - 1)) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (ram_we) begin
        fwd_v <= 1'b1;
      end
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_idx  <= ram_waddr;
      fwd_data <= fuct_pkg::entry_t'(ram_wdata);
    end
    if (accept) begin
      s1_req  <= req_type;
      s1_idx  <= in_idx;
      s1_val  <= operand_value;
      s1_miss <= in_miss;
    end
    if (s1_adv) begin
      usage_out   <= s1_miss ? '0 : upd.usage;
      answer_flag <= s1_miss ? 1'b0 : upd_ans;
      miss        <= s1_miss;
    end
  end

  // no item enters while the ram is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during clearing pass");

  // a missed file number leaves the table untouched
  a_miss_no_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clearing) |-> !s1_miss)
    else $error("table written for a missed file number");

  // a miss result carries no count and no answer
  a_miss_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && miss) |-> ((usage_out == '0) && !answer_flag))
    else $error("miss result with nonzero fields");

  // the stage register only moves forward when the result side has room
  a_stage_room: assert property (@(posedge clk) disable iff (rst)
    (s1_v && out_valid && !out_ready) |=> (s1_v && $stable(s1_idx)))
    else $error("request stage lost an item under back pressure");

endmodule

/* bench/tb.sv */
// testbench for file_usage_count_table: directed and random requests with a
// scoreboard class that predicts every reply from its own copy of the table
// depends on fuct_pkg and the file_usage_count_table rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_FILES = 64;
  localparam logic [fuct_pkg::USAGE_W-1:0] USAGE_MAX = '1;
  localparam int RANDOM_ITEMS = 1650;
  // codes past the last request have no meaning to the block
  localparam logic [fuct_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = fuct_pkg::REQ_PENDING + 1'b1;
  localparam logic [fuct_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [fuct_pkg::USAGE_W-1:0] usage;
    logic                         answer;
    logic                         miss;
  } reply_t;

  class usage_table_board;
    logic [fuct_pkg::USAGE_W-1:0] usage_tbl [NUM_FILES];
    logic [fuct_pkg::VAL_W-1:0]   stamp_tbl [NUM_FILES];
    logic                         pend_tbl  [NUM_FILES];
    reply_t                       awaited_replies [$];
    int requests_noted = 0;
    int replies_checked = 0;
    int misses_seen = 0;
    int true_answers = 0;
    int errors = 0;

    function new();
      for (int i = 0; i < NUM_FILES; i++) begin
        usage_tbl[i] = '0;
        stamp_tbl[i] = '0;
        pend_tbl[i]  = 1'b0;
      end
    endfunction

    function int outstanding();
      return awaited_replies.size();
    endfunction

    // applies one accepted request to the table copy and queues its reply
    function void note_request(logic [fuct_pkg::REQ_W-1:0] req,
                               logic [fuct_pkg::FN_W-1:0] fnum,
                               logic [fuct_pkg::VAL_W-1:0] val);
      reply_t r;
      int idx;
      r = '0;
      requests_noted++;
      if (fnum == 0 || fnum > NUM_FILES) begin
        r.miss = 1'b1;
      end else begin
        idx = int'(fnum) - 1;
        case (req)
          fuct_pkg::REQ_GET: ;
          fuct_pkg::REQ_SET_USAGE: begin
            usage_tbl[idx] = (val > fuct_pkg::VAL_W'(USAGE_MAX)) ? USAGE_MAX
                           : val[fuct_pkg::USAGE_W-1:0];
          end
          fuct_pkg::REQ_INC: begin
            if (usage_tbl[idx] != USAGE_MAX) usage_tbl[idx] = usage_tbl[idx] + 1'b1;
          end
          fuct_pkg::REQ_DEC: begin
            if (usage_tbl[idx] <= 1) begin
              usage_tbl[idx] = '0;
              stamp_tbl[idx] = '0;
            end else begin
              usage_tbl[idx] = usage_tbl[idx] - 1'b1;
            end
          end
          fuct_pkg::REQ_SET_STAMP: stamp_tbl[idx] = val;
          fuct_pkg::REQ_CHECK_STAMP:
            r.answer = (stamp_tbl[idx] == val) || (stamp_tbl[idx] == 0);
          fuct_pkg::REQ_CHECK_FINISH: begin
            if (pend_tbl[idx] && usage_tbl[idx] == 0) begin
              stamp_tbl[idx] = '0;
              pend_tbl[idx]  = 1'b0;
              r.answer = 1'b1;
            end
          end
          fuct_pkg::REQ_TRY_FINISH: begin
            if (usage_tbl[idx] == 0) begin
              stamp_tbl[idx] = '0;
              r.answer = 1'b1;
            end else begin
              pend_tbl[idx] = 1'b1;
            end
          end
          fuct_pkg::REQ_PENDING: r.answer = pend_tbl[idx];
          default: ;
        endcase
        r.usage = usage_tbl[idx];
      end
      awaited_replies.push_back(r);
    endfunction

    function void compare_reply(logic [fuct_pkg::USAGE_W-1:0] usage, logic answer,
                                logic miss_bit);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("reply with no request waiting: usage_out %0d answer_flag %0b miss %0b",
               usage, answer, miss_bit);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      replies_checked++;
      if (miss_bit === 1'b1) misses_seen++;
      if (answer === 1'b1) true_answers++;
      if (usage !== want.usage) begin
        $error("usage_out: expected %0d, got %0d", want.usage, usage);
        errors++;
      end
      if (answer !== want.answer) begin
        $error("answer_flag: expected %0b, got %0b", want.answer, answer);
        errors++;
      end
      if (miss_bit !== want.miss) begin
        $error("miss: expected %0b, got %0b", want.miss, miss_bit);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [fuct_pkg::REQ_W-1:0]   req_type = '0;
  logic [fuct_pkg::FN_W-1:0]    file_number = '0;
  logic [fuct_pkg::VAL_W-1:0]   operand_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [fuct_pkg::USAGE_W-1:0] usage_out;
  logic                         answer_flag;
  logic                         miss;

  usage_table_board board = new();

  int items_sent = 0;
  logic [7:0] stall_clock = '0;
  logic [1:0] stall_mode = '0;

  file_usage_count_table #(.ENTRIES(NUM_FILES)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .file_number(file_number),
    .operand_value(operand_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .usage_out(usage_out),
    .answer_flag(answer_flag),
    .miss(miss)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: checks accepted replies, picks a new stall pattern each time the 8-bit stall clock wraps
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.compare_reply(usage_out, answer_flag, miss);
    stall_clock <= stall_clock + 1'b1;
    if (stall_clock == 0) stall_mode <= 2'($urandom_range(3));
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(1));
      2'd2: out_ready <= (stall_clock[3:0] < 4'd11);
      default: out_ready <= ($urandom_range(7) == 0);
    endcase
  end

  // raises valid with the item and returns at the edge that accepts it
  task automatic send_item(logic [fuct_pkg::REQ_W-1:0] req,
                           logic [fuct_pkg::FN_W-1:0] fnum,
                           logic [fuct_pkg::VAL_W-1:0] val);
    in_valid      <= 1'b1;
    req_type      <= req;
    file_number   <= fnum;
    operand_value <= val;
    do @(posedge clk); while (!in_ready);
    board.note_request(req, fnum, val);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // hot files get most traffic so counts and flags interact
  task automatic make_random_item(output logic [fuct_pkg::REQ_W-1:0] req,
                                  output logic [fuct_pkg::FN_W-1:0] fnum,
                                  output logic [fuct_pkg::VAL_W-1:0] val);
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) fnum = fuct_pkg::FN_W'($urandom_range(4, 1));
    else if (sel < 87) fnum = fuct_pkg::FN_W'($urandom_range(NUM_FILES, 1));
    else if (sel < 91) fnum = '0;
    else fnum = fuct_pkg::FN_W'($urandom_range(127, NUM_FILES + 1));
    sel = $urandom_range(99);
    if (sel < 95) begin
      req = fuct_pkg::REQ_W'($urandom_range(fuct_pkg::REQ_PENDING, fuct_pkg::REQ_GET));
    end else begin
      req = fuct_pkg::REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    end
    sel = $urandom_range(99);
    if (sel < 60) val = fuct_pkg::VAL_W'($urandom_range(3));
    else if (sel < 80) val = fuct_pkg::VAL_W'($urandom_range(32'h1_0001, 32'hFFFE));
    else val = $urandom();
  endtask

  initial begin
    logic [fuct_pkg::REQ_W-1:0] req;
    logic [fuct_pkg::FN_W-1:0]  fnum;
    logic [fuct_pkg::VAL_W-1:0] val;
    int burst;
    int gap;
    int smooth_left;
    bit hold;
    bit mid_drained;

    smooth_left = 0;
    mid_drained = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: saturation, clamping, stamp and finish corner cases, misses
    send_item(fuct_pkg::REQ_GET,          7'd1,   32'd0);
    send_item(fuct_pkg::REQ_SET_USAGE,    7'd1,   32'hFFFF_FFFF);
    send_item(fuct_pkg::REQ_INC,          7'd1,   32'd0);
    send_item(fuct_pkg::REQ_SET_STAMP,    7'd1,   32'hFFFF_FFFF);
    send_item(fuct_pkg::REQ_CHECK_STAMP,  7'd1,   32'd0);
    send_item(fuct_pkg::REQ_CHECK_STAMP,  7'd1,   32'hFFFF_FFFF);
    send_item(fuct_pkg::REQ_TRY_FINISH,   7'd1,   32'd0);
    send_item(fuct_pkg::REQ_PENDING,      7'd1,   32'd0);
    send_item(fuct_pkg::REQ_CHECK_FINISH, 7'd1,   32'd0);
    send_item(fuct_pkg::REQ_SET_USAGE,    7'd1,   32'd2);
    send_item(fuct_pkg::REQ_DEC,          7'd1,   32'd0);
    send_item(fuct_pkg::REQ_DEC,          7'd1,   32'd0);
    send_item(fuct_pkg::REQ_DEC,          7'd1,   32'd0);
    send_item(fuct_pkg::REQ_CHECK_STAMP,  7'd1,   32'd123);
    send_item(fuct_pkg::REQ_CHECK_FINISH, 7'd1,   32'd0);
    send_item(fuct_pkg::REQ_PENDING,      7'd1,   32'd0);
    send_item(fuct_pkg::REQ_TRY_FINISH,   7'd64,  32'd0);
    send_item(fuct_pkg::REQ_SET_USAGE,    7'd64,  32'h1_0000);
    send_item(fuct_pkg::REQ_INC,          7'd64,  32'h5555_AAAA);
    send_item(fuct_pkg::REQ_GET,          7'd0,   32'd0);
    send_item(fuct_pkg::REQ_SET_USAGE,    7'd65,  32'd9);
    send_item(fuct_pkg::REQ_INC,          7'd127, 32'hFFFF_FFFF);
    send_item(REQ_UNUSED_LAST,            7'd64,  32'd0);
    send_item(REQ_UNUSED_FIRST,           7'd2,   32'd1);
    send_item(fuct_pkg::REQ_PENDING,      7'd64,  32'd0);
    in_valid <= 1'b0;
    wait_drained();

    // random bursts with gaps, occasional runs of back-to-back bursts
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(20, 1);
      for (int k = 0; k < burst; k++) begin
        make_random_item(req, fnum, val);
        send_item(req, fnum, val);
      end
      if (smooth_left > 0) begin
        smooth_left--;
        gap = 0;
      end else begin
        if ($urandom_range(9) == 0) smooth_left = $urandom_range(12, 4);
        gap = $urandom_range(6);
      end
      hold = !mid_drained && items_sent >= RANDOM_ITEMS / 2;
      if (gap > 0 || hold) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (hold) begin
          wait_drained();
          mid_drained = 1;
        end
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run: %0d requests, %0d replies checked, %0d misses, %0d true answers",
             board.requests_noted, board.replies_checked, board.misses_seen,
             board.true_answers);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
